// ----- rtl/spqu_pkg.sv -----
package spqu_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int CMD_W = 2;
  localparam int ID_W = 8;
  localparam int PRIO_W = 2;
  localparam int STATUS_W = 3;
  localparam int ENTRY_COUNT_W = 5;

  localparam logic [PRIO_W-1:0] PRIO_NONE = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_NORMAL = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_UPDATE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_UNCHANGED = 3'd4
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_WR,
    S_DEQ_RD,
    S_DEQ_TAKE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIND_RD,
    S_FIND_CHK,
    S_FRONT_RD,
    S_FRONT_WAIT
  } state_t;

endpackage

// ----- rtl/stable_priority_queue_with_update_unit.sv -----
// Bounded priority queue of DEPTH slots, highest priority first and first in first out
// within a level, with enqueue, dequeue and update requests. A request is taken when start
// is high and busy is low; its single result appears for exactly one cycle with done high,
// and the receiver cannot stall it, so it must capture the result in that cycle. The slots
// live in one memory with a registered read port, and a small sequencer walks them through a
// single compare and move step for each slot visited. An enqueue moves lower-priority entries
// down one slot from the tail and writes the new entry behind the last one of equal or higher
// priority; a dequeue takes the front entry and shifts the rest up; an update searches for
// the identifier, and when its priority differs it removes the entry and reinserts it. A full
// enqueue, an empty dequeue or an unknown command goes straight to the front read and visits
// no slot.
module stable_priority_queue_with_update_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [spqu_pkg::CMD_W-1:0]         command,
  input  logic [spqu_pkg::ID_W-1:0]          entry_id,
  input  logic [spqu_pkg::PRIO_W-1:0]        entry_priority,
  output logic                               done,
  output logic [spqu_pkg::STATUS_W-1:0]      status,
  output logic [spqu_pkg::ID_W-1:0]          taken_id,
  output logic [spqu_pkg::PRIO_W-1:0]        taken_priority,
  output logic [spqu_pkg::ENTRY_COUNT_W-1:0] entry_count,
  output logic [spqu_pkg::ID_W-1:0]          front_id,
  output logic                               front_valid
);
  import spqu_pkg::*;

  state_t state, state_next;

  slot_t slots [DEPTH];
  slot_t rd_data;
  slot_t wr_data;
  logic rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr_dec, ptr_inc;
  cmd_t cmd;
  logic [ID_W-1:0] id;
  logic [PRIO_W-1:0] prio;
  status_t status_r;
  logic [ID_W-1:0] taken_id_r;
  logic [PRIO_W-1:0] taken_prio_r;
  logic [ID_W-1:0] front_id_r;
  logic front_valid_r;

  logic accept;
  logic prio_ge;
  logic last_shift;

  assign accept = start && (state == S_IDLE);
  assign ptr_dec = ptr - CNT_W'(1);
  assign ptr_inc = ptr + CNT_W'(1);
  assign prio_ge = (rd_data.prio >= prio);
  assign last_shift = (ptr_inc >= count);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd_t'(command))
            CMD_ENQUEUE: state_next = (count >= CNT_W'(DEPTH)) ? S_FRONT_RD : S_ENQ_RD;
            CMD_DEQUEUE: state_next = (count == '0) ? S_FRONT_RD : S_DEQ_RD;
            CMD_UPDATE:  state_next = S_FIND_RD;
            default:     state_next = S_FRONT_RD;
          endcase
        end
      end
      S_ENQ_RD:   state_next = (ptr == '0) ? S_FRONT_RD : S_ENQ_WR;
      S_ENQ_WR:   state_next = prio_ge ? S_FRONT_RD : S_ENQ_RD;
      S_DEQ_RD:   state_next = S_DEQ_TAKE;
      S_DEQ_TAKE: state_next = S_SHIFT_RD;
      S_SHIFT_RD: begin
        if (last_shift) begin
          state_next = (cmd == CMD_UPDATE) ? S_ENQ_RD : S_FRONT_RD;
        end else begin
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_FIND_RD:  state_next = (ptr >= count) ? S_FRONT_RD : S_FIND_CHK;
      S_FIND_CHK: begin
        if (rd_data.id == id) begin
          state_next = (rd_data.prio == prio) ? S_FRONT_RD : S_SHIFT_RD;
        end else begin
          state_next = S_FIND_RD;
        end
      end
      S_FRONT_RD:   state_next = S_FRONT_WAIT;
      S_FRONT_WAIT: state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = ptr[IDX_W-1:0];
    wr_data = rd_data;
    case (state)
      S_ENQ_RD: begin
        if (ptr == '0) begin
          wr_en = 1'b1;
          wr_data = '{id: id, prio: prio};
        end else begin
          rd_en = 1'b1;
          rd_addr = ptr_dec[IDX_W-1:0];
        end
      end
      S_ENQ_WR: begin
        wr_en = 1'b1;
        if (prio_ge) begin
          wr_data = '{id: id, prio: prio};
        end
      end
      S_DEQ_RD, S_FRONT_RD: begin
        rd_en = 1'b1;
      end
      S_SHIFT_RD: begin
        if (!last_shift) begin
          rd_en = 1'b1;
          rd_addr = ptr_inc[IDX_W-1:0];
        end
      end
      S_SHIFT_WR: begin
        wr_en = 1'b1;
      end
      S_FIND_RD: begin
        if (ptr < count) begin
          rd_en = 1'b1;
          rd_addr = ptr[IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= slots[rd_addr];
    end
    if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_FRONT_WAIT);
      if ((state == S_ENQ_RD && ptr == '0) || (state == S_ENQ_WR && prio_ge)) begin
        count <= count + CNT_W'(1);
      end else if (state == S_SHIFT_RD && last_shift) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd <= cmd_t'(command);
          id <= entry_id;
          prio <= (entry_priority == PRIO_NONE) ? PRIO_NORMAL : entry_priority;
          taken_id_r <= '0;
          taken_prio_r <= PRIO_NONE;
          case (cmd_t'(command))
            CMD_ENQUEUE: begin
              ptr <= count;
              status_r <= (count >= CNT_W'(DEPTH)) ? ST_FULL : ST_OK;
            end
            CMD_DEQUEUE: begin
              ptr <= '0;
              status_r <= (count == '0) ? ST_EMPTY : ST_OK;
            end
            default: begin
              ptr <= '0;
              status_r <= ST_OK;
            end
          endcase
        end
      end
      S_ENQ_WR: begin
        if (!prio_ge) begin
          ptr <= ptr_dec;
        end
      end
      S_DEQ_TAKE: begin
        taken_id_r <= rd_data.id;
        taken_prio_r <= rd_data.prio;
      end
      S_SHIFT_RD: begin
        if (last_shift) begin
          ptr <= count - CNT_W'(1);
        end
      end
      S_SHIFT_WR: begin
        ptr <= ptr_inc;
      end
      S_FIND_RD: begin
        if (ptr >= count) begin
          status_r <= ST_NOT_FOUND;
        end
      end
      S_FIND_CHK: begin
        if (rd_data.id == id) begin
          if (rd_data.prio == prio) begin
            status_r <= ST_UNCHANGED;
          end
        end else begin
          ptr <= ptr_inc;
        end
      end
      S_FRONT_WAIT: begin
        front_valid_r <= (count != '0);
        front_id_r <= (count != '0) ? rd_data.id : '0;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign status = status_r;
  assign taken_id = taken_id_r;
  assign taken_priority = taken_prio_r;
  assign entry_count = ENTRY_COUNT_W'(count);
  assign front_id = front_id_r;
  assign front_valid = front_valid_r;

`ifndef ASSERT_OFF
  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a request is in progress");

  a_front_matches_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (front_valid == (entry_count != '0)))
    else $error("front valid disagrees with entry count");

  a_taken_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (taken_id == '0 && taken_priority == PRIO_NONE))
    else $error("taken entry reported on a failed request");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");
`endif

endmodule
